### rtl/ldrb_pkg.sv
package ldrb_pkg;

    localparam int STORE_BYTES_DEF = 16384;
    localparam int MAX_COLS_DEF    = 256;
    localparam int MAX_ROWS_DEF    = 256;

    localparam logic [15:0] BASE_LOWER = 16'h8200;
    localparam logic [15:0] BASE_UPPER = 16'h0200;

    localparam int MAX_OUT = 64;

    // Configuration register indexes.
    localparam logic [2:0] REG_COLS  = 3'd0;
    localparam logic [2:0] REG_ROWS  = 3'd1;
    localparam logic [2:0] REG_CELL  = 3'd2;
    localparam logic [2:0] REG_DUAL  = 3'd3;
    localparam logic [2:0] REG_GAP   = 3'd4;

    // Item function codes: pixel write or flush.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch item and compute geometry products
        logic divide;     // run one step of the divider
        logic pix_read;   // read work byte for a pixel write
        logic pix_write;  // write the modified work byte
        logic scan_read;  // read both stores at the scan pointer
        logic scan_eval;  // compare read bytes and update run tracking
        logic emit_read;  // read work byte at the emit pointer
        logic emit_push;  // put out one result byte
        logic emit_init;  // set the emit pointer to the run start
        logic scan_init;  // set scan pointer to span start
    } ldrb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic is_flush;
        logic span_empty;
        logic scan_end;     // scan pointer reached span end
        logic run_close;    // evaluated byte closes the open run
        logic in_run;
        logic emit_end;     // emit pointer passed the last differing byte
        logic emit_last;    // emit pointer sits on the last differing byte
        logic out_full;     // result count has reached its limit
    } ldrb_stat_t;

endpackage

### rtl/ldrb_if.sv
interface ldrb_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] row;
    logic [7:0] col;
    logic       pixel_black;
    logic [8:0] span_width;
    modport source (output valid, func, row, col, pixel_black, span_width, input ready);
    modport sink (input valid, func, row, col, pixel_black, span_width, output ready);
endinterface

interface ldrb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] display_address;
    logic [7:0]  data_byte;
    logic        run_start;
    logic        last;
    modport source (output valid, display_address, data_byte, run_start, last, input ready);
    modport sink (input valid, display_address, data_byte, run_start, last, output ready);
endinterface

interface ldrb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/lcd_dirty_run_blitter.sv
// Dirty-run blitter for a packed-pixel graphic display.
// Input channel: pixel writes (func 0) set or clear one bit in the working
// frame store; flush items (func 1) compare one row segment against the
// shown copy and emit dirty-run bytes, up to MAX_OUT, as address/data items.
// Configuration channel: registers 0..4 are columns, rows, cell width, dual
// scan and merge gap; write them only while the block is idle.
// After reset both stores are cleared, one byte a cycle, and input is first
// accepted once the clear has finished.
// A pixel write runs the 18-step serial divider, a setup step, a read and a
// write of the store, and returns to idle to accept the next item. A flush
// runs the same divide and setup, then reads and evaluates each scanned byte,
// and for each run reads and puts out every byte from its start to its end.
// The output holds its item while the receiver stalls, and the block waits.
module lcd_dirty_run_blitter
    import ldrb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    ldrb_in_if.sink    in_ch,
    ldrb_out_if.source out_ch,
    ldrb_cfg_if.sink   cfg
);

    logic [8:0] cols_reg, rows_reg;
    logic [3:0] cell_reg, gap_reg;
    logic       dual_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cols_reg <= 9'd240;
            rows_reg <= 9'd64;
            cell_reg <= 4'd6;
            dual_reg <= 1'b0;
            gap_reg  <= 4'd4;
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_COLS: cols_reg <= cfg.data;
                REG_ROWS: rows_reg <= cfg.data;
                REG_CELL: cell_reg <= cfg.data[3:0];
                REG_DUAL: dual_reg <= cfg.data[0];
                REG_GAP:  gap_reg  <= cfg.data[3:0];
                default: ;
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    ldrb_cmd_t  cmd;
    ldrb_stat_t stat;
    logic       clr_active, clr_done, dp_last, ctl_last;

    ldrb_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid (in_ch.valid), .in_ready (in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_last (ctl_last),
        .clr_done, .clr_active, .stat, .cmd
    );

    ldrb_datapath #(.STORE_BYTES(STORE_BYTES), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS))
    u_dp (
        .clk, .rst_n, .cmd, .stat, .clr_active,
        .in_func(in_ch.func), .in_row(in_ch.row), .in_col(in_ch.col),
        .in_black(in_ch.pixel_black), .in_width(in_ch.span_width),
        .cfg_cols(cols_reg), .cfg_rows(rows_reg), .cfg_cell(cell_reg),
        .cfg_dual(dual_reg), .cfg_gap(gap_reg),
        .res_address(out_ch.display_address), .res_byte(out_ch.data_byte),
        .res_start(out_ch.run_start), .res_last(dp_last), .clr_done
    );

    assign out_ch.last = dp_last | ctl_last;

    // No item is accepted while the stores are being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active |-> !in_ch.ready) else $error("input ready during clear");

    // Results and input acceptance never overlap.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_ch.valid && in_ch.ready)) else $error("ready while emitting");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");

endmodule

### rtl/ldrb_datapath.sv
module ldrb_datapath
    import ldrb_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ldrb_cmd_t   cmd,
    output ldrb_stat_t  stat,
    input  logic        clr_active,
    input  logic        in_func,
    input  logic [7:0]  in_row,
    input  logic [7:0]  in_col,
    input  logic        in_black,
    input  logic [8:0]  in_width,
    input  logic [8:0]  cfg_cols,
    input  logic [8:0]  cfg_rows,
    input  logic [3:0]  cfg_cell,
    input  logic        cfg_dual,
    input  logic [3:0]  cfg_gap,
    output logic [15:0] res_address,
    output logic [7:0]  res_byte,
    output logic        res_start,
    output logic        res_last,
    output logic        clr_done
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int LW = 18;            // linear pixel index width
    localparam int CW = 9;             // column count width

    // Item and geometry registers.
    logic          func_reg;
    logic          black_reg;
    logic [2:0]    bitpos_reg;
    logic [LW-1:0] endlin_reg;
    logic [3:0]    cell_reg;
    logic          lower_reg;

    // Restoring dividers on a shared divisor, one quotient bit a cycle, three divides in parallel.
    // Divide 0 gives the byte index, divide 1 the span end, and divide 2 either
    // the column remainder of a pixel or the lower-half base offset of a flush.
    logic [LW-1:0] q0_reg, q1_reg, q2_reg;
    logic [3:0]    r0_reg, r1_reg, r2_reg;
    logic [4:0]    div_cnt_reg;

    logic [AW:0]   start_reg;
    logic [AW:0]   endx_reg;
    logic [AW:0]   scan_reg;
    logic [AW:0]   rs_reg;
    logic [AW:0]   ld_reg;
    logic [AW:0]   emit_reg;
    logic          inrun_reg;
    logic [6:0]    cnt_reg;
    logic [15:0]   base_reg;

    // Stores and their read registers.
    logic [7:0]    work_mem  [STORE_BYTES];
    logic [7:0]    shown_mem [STORE_BYTES];
    logic [7:0]    work_rd_reg;
    logic [7:0]    shown_rd_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [8:0]    cols_eff, rows_eff, width_eff;
    logic [3:0]    cell_eff;

    always_comb
    begin
        cols_eff  = (cfg_cols > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cfg_cols;
        rows_eff  = (cfg_rows > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : cfg_rows;
        width_eff = (in_width > 9'(MAX_COLS)) ? 9'(MAX_COLS) : in_width;
        cell_eff  = (cfg_cell < 4'd5) ? 4'd5 : ((cfg_cell > 4'd8) ? 4'd8 : cfg_cell);
    end

    // Divider step helper.
    function automatic logic [LW+3:0] div_step(input logic [LW-1:0] q, input logic [3:0] r,
                                               input logic [3:0] d);
        logic [4:0] t;
        logic [3:0] rn;
        logic       b;
        begin
            t  = {r, q[LW-1]};
            b  = (t >= {1'b0, d});
            rn = b ? 4'(t - {1'b0, d}) : t[3:0];
            return {rn, q[LW-2:0], b};
        end
    endfunction

    logic [LW+3:0] s0, s1, s2;
    assign s0 = div_step(q0_reg, r0_reg, cell_reg);
    assign s1 = div_step(q1_reg, r1_reg, cell_reg);
    assign s2 = div_step(q2_reg, r2_reg, cell_reg);

    logic eq_byte;
    logic [AW:0] gap;
    assign eq_byte = (work_rd_reg == shown_rd_reg);
    assign gap     = scan_reg - ld_reg - 1'b1;

    // Geometry, divider and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            div_cnt_reg  <= '0;
            inrun_reg    <= 1'b0;
            cnt_reg      <= '0;
            clr_addr_reg <= '0;
            clr_done     <= 1'b0;
        end else begin
            if (clr_active) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(STORE_BYTES - 1))
                    clr_done <= 1'b1;
            end
            if (cmd.load) begin
                div_cnt_reg <= 5'(LW);
                inrun_reg   <= 1'b0;
                cnt_reg     <= '0;
            end else if (cmd.divide && div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (cmd.scan_eval && !eq_byte) begin
                inrun_reg <= 1'b1;
            end
            if (cmd.emit_init)
                inrun_reg <= 1'b0;
            if (cmd.emit_push)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    logic [LW-1:0] lin_c;
    logic [LW-1:0] endlin_c;
    assign lin_c    = LW'(in_row) * LW'(cols_eff) + LW'(in_col);
    assign endlin_c = lin_c + LW'(width_eff) + LW'(cell_eff) - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            func_reg    <= in_func;
            black_reg   <= in_black;
            cell_reg    <= cell_eff;
            endlin_reg  <= (width_eff == '0) ? '0 : endlin_c;
            lower_reg   <= cfg_dual && ({1'b0, in_row} >= (rows_eff >> 1));
            q0_reg      <= lin_c;
            q1_reg      <= endlin_c;
            q2_reg      <= in_func ? ((LW'(cols_eff) * LW'(rows_eff)) >> 1) : LW'(in_col);
            r0_reg      <= '0;
            r1_reg      <= '0;
            r2_reg      <= '0;
            bitpos_reg  <= '0;
        end else if (cmd.divide && div_cnt_reg != '0) begin
            {r0_reg, q0_reg} <= s0;
            {r1_reg, q1_reg} <= s1;
            {r2_reg, q2_reg} <= s2;
        end
        if (cmd.scan_init) begin
            start_reg <= (q0_reg >= LW'(STORE_BYTES)) ? (AW+1)'(STORE_BYTES)
                                                       : (AW+1)'(q0_reg);
            endx_reg  <= (q1_reg > LW'(STORE_BYTES)) ? (AW+1)'(STORE_BYTES)
                                                      : (AW+1)'(q1_reg);
            scan_reg  <= (q0_reg >= LW'(STORE_BYTES)) ? (AW+1)'(STORE_BYTES)
                                                       : (AW+1)'(q0_reg);
            base_reg  <= lower_reg ? 16'(BASE_LOWER - 16'(q2_reg)) : BASE_UPPER;
            // Bit of the pixel: cell-1 - col%cell, with col%cell left in r2.
            bitpos_reg <= 3'(cell_reg - 4'd1 - r2_reg);
        end
        if (cmd.scan_eval) begin
            if (!eq_byte) begin
                if (!inrun_reg)
                    rs_reg <= scan_reg;
                ld_reg <= scan_reg;
            end
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.emit_init)
            emit_reg <= rs_reg;
        if (cmd.emit_push)
            emit_reg <= emit_reg + 1'b1;
    end

    // Run tracking after close: a new run starts at the byte that closed the last one.
    logic close_c;
    assign close_c = inrun_reg && !eq_byte && (gap > (AW+1)'(cfg_gap));

    // Memory access.
    logic [AW-1:0] rd_addr;
    logic [7:0]    pix_byte;
    always_comb
    begin
        rd_addr = AW'(scan_reg);
        if (cmd.emit_read)
            rd_addr = AW'(emit_reg);
        else if (cmd.pix_read)
            rd_addr = AW'(q0_reg);
        pix_byte = black_reg ? (work_rd_reg | (8'd1 << bitpos_reg))
                             : (work_rd_reg & ~(8'd1 << bitpos_reg));
    end

    always_ff @(posedge clk)
    begin
        work_rd_reg  <= work_mem[rd_addr];
        shown_rd_reg <= shown_mem[rd_addr];
        if (clr_active) begin
            work_mem[clr_addr_reg]  <= '0;
            shown_mem[clr_addr_reg] <= '0;
        end else begin
            if (cmd.pix_write && q0_reg < LW'(STORE_BYTES))
                work_mem[AW'(q0_reg)] <= pix_byte;
            if (cmd.emit_push)
                shown_mem[AW'(emit_reg)] <= work_rd_reg;
        end
    end

    assign res_address = 16'(base_reg + 16'(emit_reg));
    assign res_byte    = work_rd_reg;
    assign res_start   = (emit_reg == rs_reg);
    assign res_last    = 1'b0;

    always_comb
    begin
        stat.div_done   = (div_cnt_reg == '0);
        stat.is_flush   = func_reg;
        stat.span_empty = (endlin_reg == '0) || (start_reg >= endx_reg);
        stat.scan_end   = (scan_reg >= endx_reg);
        stat.run_close  = close_c;
        stat.in_run     = inrun_reg;
        stat.emit_end   = (emit_reg > ld_reg);
        stat.emit_last  = (emit_reg == ld_reg);
        stat.out_full   = (cnt_reg >= 7'(MAX_OUT));
    end

endmodule

### rtl/ldrb_ctrl.sv
module ldrb_ctrl
    import ldrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_last,
    input  logic       clr_done,
    output logic       clr_active,
    input  ldrb_stat_t stat,
    output ldrb_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_SETUP, S_PIX_RD, S_PIX_WR,
        S_SCAN_RD, S_SCAN_EV, S_EMIT_RD, S_EMIT_OUT, S_RESUME, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;   // emitting the last run of the span
    logic   pend_out_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: if (clr_done) state_next = S_IDLE;
            S_IDLE:
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            S_DIV: begin
                cmd.divide = 1'b1;
                if (stat.div_done) state_next = S_SETUP;
            end
            S_SETUP: begin
                cmd.scan_init = 1'b1;
                state_next    = stat.is_flush ? S_SCAN_RD : S_PIX_RD;
            end
            S_PIX_RD: begin
                cmd.pix_read = 1'b1;
                state_next   = S_PIX_WR;
            end
            S_PIX_WR: begin
                cmd.pix_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN_RD:
                if (stat.span_empty || stat.scan_end) begin
                    final_next = 1'b1;
                    state_next = stat.in_run ? S_EMIT_RD : S_IDLE;
                    cmd.emit_init = stat.in_run;
                end else begin
                    state_next = S_SCAN_EV;
                end
            S_SCAN_EV:
                if (stat.run_close) begin
                    final_next    = 1'b0;
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT_RD;
                end else begin
                    cmd.scan_eval = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            S_EMIT_RD:
                if (stat.emit_end || stat.out_full) begin
                    state_next = final_reg ? S_IDLE : S_SCAN_EV;
                end else begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_EMIT_OUT;
                end
            S_EMIT_OUT: begin
                // Keep reading the same byte so the offered item holds during a stall.
                cmd.emit_read = 1'b1;
                if (out_ready) begin
                    cmd.emit_push = 1'b1;
                    state_next    = S_EMIT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_CLEAR;
            final_reg    <= 1'b0;
            pend_out_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            final_reg    <= final_next;
            pend_out_reg <= (state_next == S_EMIT_OUT);
        end
    end

    assign clr_active = (state_reg == S_CLEAR);
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_EMIT_OUT) && pend_out_reg;
    // The final run of a span always holds the last differing byte.
    assign out_last   = (state_reg == S_EMIT_OUT) && final_reg && stat.emit_last;

endmodule

### test/tb_lcd_dirty_run_blitter.sv
module tb_lcd_dirty_run_blitter;
    import ldrb_pkg::*;

    localparam int STORE = STORE_BYTES_DEF;
    localparam int WATCH_LIMIT = 100000;

    typedef struct packed {
        logic       func;
        logic [7:0] row;
        logic [7:0] col;
        logic       black;
        logic [8:0] width;
    } blit_item_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        logic        rstart;
        logic        last;
    } byte_write_t;

    logic clk;
    logic rst_n;

    ldrb_in_if  in_ch();
    ldrb_out_if out_ch();
    ldrb_cfg_if cfg();

    lcd_dirty_run_blitter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Predictor state: the two frame stores and the register copies.
    logic [7:0] work_mem [STORE];
    logic [7:0] shown_mem [STORE];
    int unsigned p_cols, p_rows, p_cell, p_dual, p_gap;

    blit_item_t  pending_items[$];
    byte_write_t expected_writes[$];

    int  errors;
    int  writes_seen;
    int  idle_cnt;
    int  in_hold;
    int  out_hold;
    bit  calm;
    bit  cfg_req;
    logic [2:0] cfg_idx_req;
    logic [8:0] cfg_val_req;
    bit  cfg_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Append the bytes of one dirty run to the expected writes.
    task automatic queue_run(int unsigned first, int unsigned lastb, int unsigned base);
        byte_write_t w;
        for (int unsigned k = first; k <= lastb; k++)
        begin
            w.addr   = 16'((base + k) & 16'hFFFF);
            w.data   = work_mem[k];
            w.rstart = (k == first);
            w.last   = 1'b0;
            shown_mem[k] = work_mem[k];
            expected_writes.push_back(w);
        end
    endtask

    // Work out the effect of one accepted item.
    task automatic predict_item(blit_item_t it);
        int unsigned cols, rows, cellw, lin, idx, wid, start, endx, base, rs, ld;
        int unsigned before_cnt;
        bit inrun;
        logic [7:0] mask;
        cols = (p_cols > 256) ? 256 : p_cols;
        rows = (p_rows > 256) ? 256 : p_rows;
        cellw = (p_cell < 5) ? 5 : ((p_cell > 8) ? 8 : p_cell);
        lin = it.row * cols + it.col;
        if (it.func == FUNC_PIXEL)
        begin
            idx = lin / cellw;
            mask = 8'(1 << (cellw - 1 - it.col % cellw));
            if (idx < STORE)
                work_mem[idx] = it.black ? (work_mem[idx] | mask) : (work_mem[idx] & ~mask);
            return;
        end
        wid = (it.width > 256) ? 256 : it.width;
        if (wid == 0)
            return;
        start = lin / cellw;
        endx = (lin + wid + cellw - 1) / cellw;
        if (endx > STORE)
            endx = STORE;
        if (start >= endx)
            return;
        if (p_dual != 0 && it.row >= rows / 2)
            base = (32'h8200 - (cols * rows / 2) / cellw) & 32'hFFFF;
        else
            base = 32'h0200;
        before_cnt = expected_writes.size();
        inrun = 1'b0;
        rs = 0;
        ld = 0;
        for (int unsigned i = start; i < endx; i++)
        begin
            if (work_mem[i] == shown_mem[i])
                continue;
            if (inrun && (i - ld - 1) > p_gap)
            begin
                queue_run(rs, ld, base);
                inrun = 1'b0;
            end
            if (!inrun)
            begin
                rs = i;
                inrun = 1'b1;
            end
            ld = i;
        end
        if (inrun)
            queue_run(rs, ld, base);
        if (expected_writes.size() > before_cnt)
            expected_writes[expected_writes.size() - 1].last = 1'b1;
    endtask

    function automatic blit_item_t make_pixel(int r, int c, bit b);
        blit_item_t it;
        it.func = FUNC_PIXEL;
        it.row = 8'(r);
        it.col = 8'(c);
        it.black = b;
        it.width = 9'($urandom);
        return it;
    endfunction

    function automatic blit_item_t make_flush(int r, int c, int w);
        blit_item_t it;
        it.func = FUNC_FLUSH;
        it.row = 8'(r);
        it.col = 8'(c);
        it.black = 1'($urandom);
        it.width = 9'(w);
        return it;
    endfunction

    // Driver: feeds pending items, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.func <= 1'b0;
            in_ch.row <= '0;
            in_ch.col <= '0;
            in_ch.pixel_black <= 1'b0;
            in_ch.span_width <= '0;
            in_hold <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_item(pending_items.pop_front());
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_hold > 0)
                begin
                    in_hold <= in_hold - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    in_hold <= $urandom_range(0, 6);
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.func <= pending_items[0].func;
                    in_ch.row <= pending_items[0].row;
                    in_ch.col <= pending_items[0].col;
                    in_ch.pixel_black <= pending_items[0].black;
                    in_ch.span_width <= pending_items[0].width;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_hold <= 0;
        end
        else if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            out_hold <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Monitor: compares each output item with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            writes_seen <= writes_seen + 1;
            if (expected_writes.size() == 0)
            begin
                $display("%0t: unexpected item addr %h data %h", $realtime,
                         out_ch.display_address, out_ch.data_byte);
                errors <= errors + 1;
            end
            else if (expected_writes[0] !== {out_ch.display_address, out_ch.data_byte,
                                             out_ch.run_start, out_ch.last})
            begin
                $display("%0t: mismatch expected addr %h data %h start %b last %b",
                         $realtime, expected_writes[0].addr, expected_writes[0].data,
                         expected_writes[0].rstart, expected_writes[0].last);
                $display("%0t:          actual addr %h data %h start %b last %b",
                         $realtime, out_ch.display_address, out_ch.data_byte,
                         out_ch.run_start, out_ch.last);
                errors <= errors + 1;
                void'(expected_writes.pop_front());
            end
            else
                void'(expected_writes.pop_front());
        end
    end

    // Configuration channel driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.valid <= 1'b0;
            cfg.index <= '0;
            cfg.data <= '0;
            cfg_done <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            cfg.valid <= 1'b0;
            cfg_done <= 1'b1;
        end
        else if (cfg_req && !cfg.valid && !cfg_done)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= cfg_idx_req;
            cfg.data <= cfg_val_req;
        end
        else if (!cfg_req)
            cfg_done <= 1'b0;
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WATCH_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        cfg_idx_req = idx;
        cfg_val_req = 9'(val);
        cfg_req = 1'b1;
        @(posedge clk);
        while (!cfg_done)
            @(posedge clk);
        cfg_req = 1'b0;
        // Let the request handshake settle before the next write.
        while (cfg_done)
            @(posedge clk);
        case (idx)
            REG_COLS: p_cols = val & 9'h1FF;
            REG_ROWS: p_rows = val & 9'h1FF;
            REG_CELL: p_cell = val & 4'hF;
            REG_DUAL: p_dual = val & 1;
            default:  p_gap = val & 4'hF;
        endcase
    endtask

    // Wait until all items are in, the block is idle and every expected write has come out.
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || !in_ch.ready
               || expected_writes.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_geometry(int c, int r, int cw, int d, int g);
        drain();
        write_reg(REG_COLS, c);
        write_reg(REG_ROWS, r);
        write_reg(REG_CELL, cw);
        write_reg(REG_DUAL, d);
        write_reg(REG_GAP, g);
    endtask

    // One random phase: mostly pixels on random rows mixed with flushes, then a full-row flush.
    task automatic random_phase(int n);
        int r, c;
        for (int i = 0; i < n; i++)
        begin
            r = (p_rows > 0) ? $urandom_range(0, (p_rows > 256 ? 256 : p_rows) - 1) : 0;
            if ($urandom_range(0, 9) == 0)
                r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(make_flush(r, $urandom_range(0, 255) & ~7,
                                                   $urandom_range(0, 4) == 0 ?
                                                   $urandom_range(0, 511) :
                                                   $urandom_range(1, 60)));
            else
                pending_items.push_back(make_pixel(r, c, $urandom_range(0, 3) != 0));
        end
        pending_items.push_back(make_flush(r, 0, 256));
    endtask

    initial
    begin
        errors = 0;
        writes_seen = 0;
        idle_cnt = 0;
        calm = 1'b0;
        cfg_req = 1'b0;
        cfg_idx_req = '0;
        cfg_val_req = '0;
        for (int i = 0; i < STORE; i++)
        begin
            work_mem[i] = '0;
            shown_mem[i] = '0;
        end
        p_cols = 240;
        p_rows = 64;
        p_cell = 6;
        p_dual = 0;
        p_gap = 4;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // Directed: corners, both pixel values, empty and oversize flushes.
        pending_items.push_back(make_pixel(0, 0, 1'b1));
        pending_items.push_back(make_pixel(0, 5, 1'b1));
        pending_items.push_back(make_pixel(0, 40, 1'b1));
        pending_items.push_back(make_pixel(63, 239, 1'b1));
        pending_items.push_back(make_pixel(255, 255, 1'b1));
        pending_items.push_back(make_flush(0, 0, 0));
        pending_items.push_back(make_flush(0, 0, 256));
        pending_items.push_back(make_flush(0, 0, 256));
        pending_items.push_back(make_pixel(0, 0, 1'b0));
        pending_items.push_back(make_flush(0, 0, 511));
        pending_items.push_back(make_flush(63, 230, 20));
        pending_items.push_back(make_flush(255, 255, 1));
        drain();

        // Dual scan, wide gap, small cell.
        set_geometry(256, 256, 5, 1, 15);
        pending_items.push_back(make_pixel(200, 3, 1'b1));
        pending_items.push_back(make_pixel(200, 250, 1'b1));
        pending_items.push_back(make_flush(200, 0, 256));
        pending_items.push_back(make_pixel(255, 255, 1'b1));
        pending_items.push_back(make_flush(255, 200, 256));
        random_phase(50);

        // Out-of-range register values and zero gap.
        set_geometry(511, 300, 15, 1, 0);
        random_phase(50);
        set_geometry(1, 1, 0, 0, 2);
        random_phase(40);
        set_geometry(128, 100, 8, 1, 7);
        random_phase(60);

        // Final part without idling.
        drain();
        calm = 1'b1;
        set_geometry(240, 64, 6, 0, 4);
        random_phase(60);
        drain();

        $display("Run covered pixel writes and flushes over five register settings,");
        $display("%0d display writes checked.", writes_seen);
        if (errors == 0 && expected_writes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
